// File: src/psplat_pkg.sv
// Shared constants and types for the photon point splat block.
`default_nettype none
package psplat_pkg;
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int SUM_W = 24;
  localparam int H_W   = 50;
  localparam int NUM_W = 62;
  localparam int DEN_W = H_W + 1;
  localparam int QW    = 9;

  localparam logic [2:0] REG_ROW0   = 3'd0;
  localparam logic [2:0] REG_ROW1   = 3'd1;
  localparam logic [2:0] REG_ROW2   = 3'd2;
  localparam logic [2:0] REG_ROW3   = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;
  localparam logic [2:0] REG_SCALE  = 3'd6;

  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [QW-1:0] q;
  } div_res_t;
endpackage
`default_nettype wire

// File: src/photon_point_splat.sv
// Top level: projection, coordinate division and pixel sum update.
// A hit word takes 16 products on one shared multiplier, two 9-step divisions, 3 power
// products and one read-modify-write; an off-image miss skips the power products and the
// read-modify-write, and a depth miss also skips the divisions. One photon in flight at a
// time, so a new photon is not taken before the last one is done. Reset clears the
// 65536-entry sum memory with in_ready low; configuration writes are taken throughout.
`default_nettype none
module photon_point_splat
  import psplat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic [15:0] power_r,
  input  wire logic [15:0] power_g,
  input  wire logic [15:0] power_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             hit,
  output logic [7:0]       pixel_x,
  output logic [7:0]       pixel_y,
  output logic [23:0]      sum_r,
  output logic [23:0]      sum_g,
  output logic [23:0]      sum_b
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAC  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_NUM  = 4'd3;
  localparam logic [3:0] S_DIVX = 4'd4;
  localparam logic [3:0] S_DIVY = 4'd5;
  localparam logic [3:0] S_PW   = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_ADD  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [63:0] mrow [4];
  logic [8:0]  img_w;
  logic [8:0]  img_h;
  logic [31:0] pscale;

  logic [3:0]  state;
  logic        clearing;
  logic [AW-1:0] clr_cnt;
  logic [4:0]  cnt;

  logic signed [31:0] px [3];
  logic [15:0]        pw [3];
  logic signed [H_W-1:0] hv [4];
  logic signed [H_W:0]   sx, sy;
  logic signed [NUM_W-1:0] numx, numy;
  logic signed [H_W-1:0] prod;
  logic [16:0] addv [3];
  logic [XW-1:0] xr;
  logic [YW-1:0] yr;
  logic          xok;

  logic        r_hit;
  logic [23:0] r_sum [3];

  logic [8:0] w_eff, h_eff;
  logic [H_W-1:0] abs_z, abs_w;

  logic signed [16:0] mul_a;
  logic signed [32:0] mul_b;
  logic [1:0] mrw, mcl;
  logic [3:0] k;

  logic                    div_go;
  logic                    div_start;
  logic signed [NUM_W-1:0] div_num;
  logic                    div_done;
  div_res_t                div_res;
  logic                    q_ok;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [3*SUM_W-1:0]   ram_wdata;
  logic [3*SUM_W-1:0]   ram_rdata;
  logic [SUM_W:0]       sum_raw [3];
  logic [SUM_W-1:0]     sum_new [3];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && !clearing;

  assign w_eff = (img_w > 9'(MAX_WIDTH))  ? 9'(MAX_WIDTH)  : img_w;
  assign h_eff = (img_h > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : img_h;
  assign abs_z = hv[2][H_W-1] ? H_W'(-hv[2]) : H_W'(hv[2]);
  assign abs_w = hv[3][H_W-1] ? H_W'(-hv[3]) : H_W'(hv[3]);

  assign mrw = cnt[3:2];
  assign mcl = cnt[1:0];
  assign k   = 4'(cnt - 5'd1);

  always_comb begin
    if (state == S_PW) begin
      mul_a = {1'b0, pw[cnt[1:0]]};
      mul_b = {1'b0, pscale};
    end else begin
      mul_a = 17'($signed(mrow[mrw][16*mcl +: 16]));
      mul_b = (mcl == 2'd3) ? 33'sd65536 : 33'(px[mcl]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mrow[0] <= '0;
      mrow[1] <= '0;
      mrow[2] <= '0;
      mrow[3] <= '0;
      img_w   <= 9'd256;
      img_h   <= 9'd256;
      pscale  <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW0:   mrow[0] <= cfg_data;
        REG_ROW1:   mrow[1] <= cfg_data;
        REG_ROW2:   mrow[2] <= cfg_data;
        REG_ROW3:   mrow[3] <= cfg_data;
        REG_WIDTH:  img_w   <= cfg_data[8:0];
        REG_HEIGHT: img_h   <= cfg_data[8:0];
        REG_SCALE:  pscale  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // x division starts once numx is registered, y division when x is done
  assign q_ok = !div_res.ovf && (!div_res.neg || div_res.q == '0);
  assign div_start = div_go || (state == S_DIVX && div_done);
  assign div_num   = div_done ? numy : numx;

  psplat_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (DEN_W'({hv[3], 1'b0})),
    .done  (div_done),
    .res   (div_res)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_raw[i] = {1'b0, ram_rdata[SUM_W*i +: SUM_W]} + (SUM_W+1)'(addv[i]);
      sum_new[i] = sum_raw[i][SUM_W] ? {SUM_W{1'b1}} : sum_raw[i][SUM_W-1:0];
    end
  end

  assign ram_we    = clearing || (state == S_ADD);
  assign ram_waddr = clearing ? clr_cnt : {yr, xr};
  assign ram_wdata = clearing ? '0 : {sum_new[2], sum_new[1], sum_new[0]};

  psplat_sum_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr ({yr, xr}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
      div_go    <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == {AW{1'b1}}) begin
          clearing <= 1'b0;
        end
      end
      div_go <= (state == S_NUM);
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cnt   <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd16) begin
            state <= S_CHK;
          end
        end
        S_CHK: state <= (hv[3] == '0 || abs_z > abs_w) ? S_OUT : S_NUM;
        S_NUM: state <= S_DIVX;
        S_DIVX: begin
          if (div_done) begin
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            cnt <= '0;
            state <= (xok && q_ok && div_res.q < h_eff) ? S_PW : S_OUT;
          end
        end
        S_PW: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd3) begin
            state <= S_RD;
          end
        end
        S_RD:  state <= S_ADD;
        S_ADD: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= H_W'(mul_a * mul_b);
    case (state)
      S_IDLE: begin
        px[0] <= pos_x;
        px[1] <= pos_y;
        px[2] <= pos_z;
        pw[0] <= power_r;
        pw[1] <= power_g;
        pw[2] <= power_b;
        r_hit <= 1'b0;
      end
      S_MAC: begin
        if (cnt != 5'd0) begin
          hv[k[3:2]] <= (k[1:0] == 2'd0) ? prod : hv[k[3:2]] + prod;
        end
      end
      S_CHK: begin
        sx <= (H_W+1)'(hv[0]) + (H_W+1)'(hv[3]);
        sy <= (H_W+1)'(hv[1]) + (H_W+1)'(hv[3]);
        r_hit <= 1'b0;
        xr <= '0;
        yr <= '0;
        r_sum[0] <= '0;
        r_sum[1] <= '0;
        r_sum[2] <= '0;
      end
      S_NUM: begin
        numx <= NUM_W'(sx * $signed({1'b0, w_eff})) + NUM_W'(hv[3]);
        numy <= NUM_W'(sy * $signed({1'b0, h_eff})) + NUM_W'(hv[3]);
      end
      S_DIVX: begin
        if (div_done) begin
          xok <= q_ok && div_res.q < w_eff;
          xr  <= div_res.q[XW-1:0];
        end
      end
      S_DIVY: begin
        if (div_done) begin
          yr <= div_res.q[YW-1:0];
          if (!(xok && q_ok && div_res.q < h_eff)) begin
            xr <= '0;
            yr <= '0;
          end
        end
      end
      S_PW: begin
        if (cnt != 5'd0) begin
          addv[k[1:0]] <= (prod > H_W'(64'h1_0000_0000)) ? 17'h10000 : prod[32:16];
        end
      end
      S_ADD: begin
        r_hit    <= 1'b1;
        r_sum[0] <= sum_new[0];
        r_sum[1] <= sum_new[1];
        r_sum[2] <= sum_new[2];
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          hit     <= r_hit;
          pixel_x <= 8'(xr);
          pixel_y <= 8'(yr);
          sum_r   <= r_sum[0];
          sum_g   <= r_sum[1];
          sum_b   <= r_sum[2];
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: src/psplat_sum_ram.sv
// Pixel RGB sum memory, one write and one registered read port.
`default_nettype none
module psplat_sum_ram
  import psplat_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [3*SUM_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic [3*SUM_W-1:0]     rdata
);
  logic [3*SUM_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/psplat_div.sv
// Iterative restoring divider for the pixel coordinate, one quotient bit a cycle.
`default_nettype none
module psplat_div
  import psplat_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic signed [DEN_W-1:0] den,
  output logic                         done,
  output div_res_t                     res
);
  logic [NUM_W-1:0] an;
  logic [DEN_W-1:0] dn;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic [3:0]       cnt;
  logic             busy;

  assign an = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign dn = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'(QW);
      end else if (busy) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= an;
      dsh     <= NUM_W'({dn, 8'b0});
      res.ovf <= an >= NUM_W'({dn, 9'b0});
      res.neg <= num[NUM_W-1] ^ den[DEN_W-1];
      res.q   <= '0;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem   <= rem - dsh;
        res.q <= {res.q[QW-2:0], 1'b1};
      end else begin
        res.q <= {res.q[QW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end
endmodule
`default_nettype wire

// File: src/psplat_checker.sv
// Port-level assertions for the photon point splat block, bound to the top level.
`default_nettype none
module psplat_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        hit,
  input wire logic [7:0]  pixel_x,
  input wire logic [7:0]  pixel_y,
  input wire logic [23:0] sum_r,
  input wire logic [23:0] sum_g,
  input wire logic [23:0] sum_b
);
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> pixel_x == 8'd0 && pixel_y == 8'd0 &&
    sum_r == 24'd0 && sum_g == 24'd0 && sum_b == 24'd0)
    else $error("miss word carries nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(sum_r))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a photon is in flight");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid || !$rose(out_valid))
    else $error("result appeared one cycle after accept");
endmodule

bind photon_point_splat psplat_checker u_psplat_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .hit       (hit),
  .pixel_x   (pixel_x),
  .pixel_y   (pixel_y),
  .sum_r     (sum_r),
  .sum_g     (sum_g),
  .sum_b     (sum_b)
);
`default_nettype wire

// File: dv/tb_top.sv
// Testbench for photon_point_splat: directed and random photons checked against a local model.
`timescale 1ns / 100ps
module tb_top;
  import psplat_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_ROW0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [15:0] power_r = '0, power_g = '0, power_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic [7:0] pixel_x, pixel_y;
  logic [23:0] sum_r, sum_g, sum_b;

  typedef struct packed {
    logic hit;
    logic [7:0] px;
    logic [7:0] py;
    logic [23:0] sr;
    logic [23:0] sg;
    logic [23:0] sb;
  } splat_word_t;

  splat_word_t splat_q[$];
  logic [63:0] mrow[4];
  logic [8:0] img_w, img_h;
  logic [31:0] pgain;
  logic [23:0] acc_r[65536], acc_g[65536], acc_b[65536];
  int errors = 0;
  bit sink_idle_en = 1'b1;
  bit src_idle_en = 1'b1;

  photon_point_splat u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint signed proj_coord(longint signed hc, longint signed hw,
                                               longint signed sz);
    return ((hc + hw) * sz + hw) / (2 * hw);
  endfunction

  function automatic logic [23:0] gain_power(logic [15:0] p);
    logic [63:0] s;
    s = 64'(p) * 64'(pgain);
    if (s > 64'h1_0000_0000) s = 64'h1_0000_0000;
    return 24'(s >> 16);
  endfunction

  function automatic logic [23:0] sat_add(logic [23:0] a, logic [23:0] b);
    logic [24:0] s;
    s = 25'(a) + 25'(b);
    return s[24] ? 24'hFFFFFF : s[23:0];
  endfunction

  task automatic splat_predict(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [15:0] r, logic [15:0] g, logic [15:0] b);
    longint signed p[4], hv[4], m, we, he, cx, cy, ax, az;
    splat_word_t e;
    int a;
    p[0] = longint'($signed(x)); p[1] = longint'($signed(y));
    p[2] = longint'($signed(z)); p[3] = 65536;
    for (int i = 0; i < 4; i++) begin
      hv[i] = 0;
      for (int c = 0; c < 4; c++) begin
        m = longint'($signed(mrow[i][16*c +: 16]));
        hv[i] += m * p[c];
      end
    end
    e = '0;
    az = hv[2] < 0 ? -hv[2] : hv[2];
    ax = hv[3] < 0 ? -hv[3] : hv[3];
    if (hv[3] != 0 && az <= ax) begin
      we = img_w > 256 ? 256 : img_w;
      he = img_h > 256 ? 256 : img_h;
      cx = proj_coord(hv[0], hv[3], we);
      cy = proj_coord(hv[1], hv[3], he);
      if (cx >= 0 && cx < we && cy >= 0 && cy < he) begin
        a = int'(cy) * 256 + int'(cx);
        acc_r[a] = sat_add(acc_r[a], gain_power(r));
        acc_g[a] = sat_add(acc_g[a], gain_power(g));
        acc_b[a] = sat_add(acc_b[a], gain_power(b));
        e = '{1'b1, 8'(cx), 8'(cy), acc_r[a], acc_g[a], acc_b[a]};
      end
    end
    splat_q.push_back(e);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk) begin
    splat_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (splat_q.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        e = splat_q.pop_front();
        if (hit !== e.hit) report_mismatch("hit", hit, e.hit);
        if (pixel_x !== e.px) report_mismatch("pixel_x", pixel_x, e.px);
        if (pixel_y !== e.py) report_mismatch("pixel_y", pixel_y, e.py);
        if (sum_r !== e.sr) report_mismatch("sum_r", sum_r, e.sr);
        if (sum_g !== e.sg) report_mismatch("sum_g", sum_g, e.sg);
        if (sum_b !== e.sb) report_mismatch("sum_b", sum_b, e.sb);
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 18);
        repeat (n) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(negedge clk);
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3: mrow[idx] = val;
      REG_WIDTH: img_w = val[8:0];
      REG_HEIGHT: img_h = val[8:0];
      REG_SCALE: pgain = val[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_photon(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [15:0] r, logic [15:0] g, logic [15:0] b);
    if (src_idle_en && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 18)) @(negedge clk);
    pos_x <= x; pos_y <= y; pos_z <= z;
    power_r <= r; power_g <= g; power_b <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    splat_predict(x, y, z, r, g, b);
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (splat_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [63:0] row_of(int a, int b, int c, int d);
    return {16'(d), 16'(c), 16'(b), 16'(a)};
  endfunction

  // ortho: hx=x, hy=y, hz=z, hw=1
  task automatic set_ortho(logic [31:0] gain, logic [8:0] w, logic [8:0] h);
    cfg_write(REG_ROW0, row_of(256, 0, 0, 0));
    cfg_write(REG_ROW1, row_of(0, 256, 0, 0));
    cfg_write(REG_ROW2, row_of(0, 0, 256, 0));
    cfg_write(REG_ROW3, row_of(0, 0, 0, 256));
    cfg_write(REG_WIDTH, 64'(w));
    cfg_write(REG_HEIGHT, 64'(h));
    cfg_write(REG_SCALE, 64'(gain));
  endtask

  function automatic logic [31:0] unit_pos();
    return 32'($signed($urandom_range(0, 2 * 65536 + 8192)) - 65536 - 4096);
  endfunction

  task automatic test_reset_defaults();
    // zero matrix: w is zero, every photon misses
    send_photon(32'h0001_0000, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();
  endtask

  task automatic test_directed();
    set_ortho(32'h0001_0000, 9'd256, 9'd256);
    send_photon(0, 0, 0, 16'hFFFF, 16'h0000, 16'h8000);
    send_photon(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_photon(32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 16'h1, 16'h2, 16'h3);
    send_photon(32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_0000, 16'h1, 16'h2, 16'h3);
    send_photon(32'h0001_0000, 0, 0, 16'h1, 16'h1, 16'h1);
    send_photon(0, 0, 32'h0001_0001, 16'h1, 16'h1, 16'h1);
    send_photon(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h1, 16'h1, 16'h1);
    send_photon(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h1, 16'h1, 16'h1);
    drain();
    // huge gain saturates sums, then zero gain
    cfg_write(REG_SCALE, 64'hFFFF_FFFF);
    for (int i = 0; i < 300; i++) send_photon(0, 0, 0, 16'hFFFF, 16'h0001, 16'h7FFF);
    drain();
    cfg_write(REG_SCALE, 64'h0);
    send_photon(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();
    cfg_write(REG_WIDTH, 64'h0);
    send_photon(0, 0, 0, 16'h1, 16'h1, 16'h1);
    drain();
    cfg_write(REG_WIDTH, 64'h1FF);
    cfg_write(REG_HEIGHT, 64'h1);
    cfg_write(REG_SCALE, 64'h0001_0000);
    send_photon(32'h0000_F000, 32'h0000_F000, 0, 16'h10, 16'h20, 16'h30);
    drain();
    cfg_write(REG_HEIGHT, 64'h0);
    send_photon(0, 0, 0, 16'h1, 16'h1, 16'h1);
    drain();
  endtask

  task automatic test_random_ortho();
    set_ortho(32'h0001_0000, 9'(($urandom_range(1, 256))), 9'($urandom_range(1, 256)));
    for (int i = 0; i < 300; i++)
      send_photon(unit_pos(), unit_pos(), unit_pos(), 16'($urandom), 16'($urandom),
                  16'($urandom));
    // hold off until everything is back
    drain();
    set_ortho(32'($urandom_range(0, 32'h0004_0000)), 9'd300, 9'd1);
    for (int i = 0; i < 200; i++)
      send_photon(unit_pos(), unit_pos(), unit_pos(), 16'($urandom), 16'($urandom),
                  16'($urandom));
    drain();
  endtask

  task automatic test_random_perspective();
    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < 4; r++) begin
        if (k == 3)
          cfg_write(3'(r), {$urandom, $urandom});
        else
          cfg_write(3'(r), row_of($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
                                  $urandom_range(0, 600) - 300,
                                  $urandom_range(0, 1200) - 600));
      end
      cfg_write(REG_WIDTH, 64'($urandom_range(0, 511)));
      cfg_write(REG_HEIGHT, 64'($urandom_range(0, 511)));
      cfg_write(REG_SCALE, 64'($urandom));
      for (int i = 0; i < 150; i++)
        if (k == 3)
          send_photon($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                      16'($urandom));
        else
          send_photon(unit_pos() <<< $urandom_range(0, 3), unit_pos() <<< $urandom_range(0, 3),
                      unit_pos() <<< $urandom_range(0, 3), 16'($urandom), 16'($urandom),
                      16'($urandom));
      drain();
    end
  endtask

  task automatic test_full_rate();
    set_ortho(32'h0000_4000, 9'd16, 9'd16);
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    for (int i = 0; i < 300; i++)
      send_photon(unit_pos(), unit_pos(), unit_pos(), 16'($urandom), 16'($urandom),
                  16'($urandom));
    drain();
  endtask

  initial begin
    img_w = 9'd256;
    img_h = 9'd256;
    pgain = 32'h0001_0000;
    for (int i = 0; i < 4; i++) mrow[i] = '0;
    for (int i = 0; i < 65536; i++) begin
      acc_r[i] = '0; acc_g[i] = '0; acc_b[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed();
    test_random_ortho();
    test_random_perspective();
    test_full_rate();
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// File: photon_point_splat.f
src/psplat_pkg.sv
src/psplat_sum_ram.sv
src/psplat_div.sv
src/photon_point_splat.sv
src/psplat_checker.sv
dv/tb_top.sv
